>>> src/capsd_pkg.sv
// ----------------------------------------------------------------------------
// capsd_pkg
// Shared types and codes of the capsule signed distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package capsd_pkg;

  typedef enum logic [2:0] {
    REG_END_A_X  = 3'd0,
    REG_END_A_Y  = 3'd1,
    REG_END_A_Z  = 3'd2,
    REG_END_B_X  = 3'd3,
    REG_END_B_Y  = 3'd4,
    REG_END_B_Z  = 3'd5,
    REG_RADIUS   = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_DIV  = 2'd0,
    MODE_ZERO = 2'd1,
    MODE_ONE  = 2'd2
  } seg_mode_t;

  localparam int unsigned CFG_INDEX_BITS = 3;

endpackage

`default_nettype wire

>>> src/capsd_front.sv
// ----------------------------------------------------------------------------
// capsd_front
// Offsets D = P - A and E = B - A, then dot(D,E) and dot(E,E) over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module capsd_front #(
  parameter int C = 32,
  parameter int DW = 2 * C + 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  adv,
  input  wire                  v_i,
  input  wire  signed [C-1:0]  p_i [3],
  input  wire  signed [C-1:0]  a_i [3],
  input  wire  signed [C-1:0]  b_i [3],
  output logic                 v_o,
  output logic signed [DW-1:0] dot_o,
  output logic signed [DW-1:0] len2_o,
  output logic signed [C:0]    d_o [3],
  output logic signed [C:0]    e_o [3]
);

  localparam int PW = 2 * C + 2;

  logic              v1_r, v2_r, v3_r;
  logic signed [C:0] d1_r [3];
  logic signed [C:0] e1_r [3];
  logic signed [C:0] d2_r [3];
  logic signed [C:0] e2_r [3];
  logic signed [C:0] d3_r [3];
  logic signed [C:0] e3_r [3];
  logic signed [PW-1:0] pd_r [3];
  logic signed [PW-1:0] pe_r [3];
  logic signed [DW-1:0] dot_r, len2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= (C+1)'(p_i[i]) - (C+1)'(a_i[i]);
        e1_r[i] <= (C+1)'(b_i[i]) - (C+1)'(a_i[i]);
        pd_r[i] <= d1_r[i] * e1_r[i];
        pe_r[i] <= e1_r[i] * e1_r[i];
        d2_r[i] <= d1_r[i];
        e2_r[i] <= e1_r[i];
        d3_r[i] <= d2_r[i];
        e3_r[i] <= e2_r[i];
      end
      dot_r  <= DW'(pd_r[0]) + DW'(pd_r[1]) + DW'(pd_r[2]);
      len2_r <= DW'(pe_r[0]) + DW'(pe_r[1]) + DW'(pe_r[2]);
    end
  end

  assign v_o    = v3_r;
  assign dot_o  = dot_r;
  assign len2_o = len2_r;
  assign d_o    = d3_r;
  assign e_o    = e3_r;

endmodule

`default_nettype wire

>>> src/capsd_div.sv
// ----------------------------------------------------------------------------
// capsd_div
// Segment parameter H = clamp(dot / len2, 0, 1): one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module capsd_div #(
  parameter int C = 32,
  parameter int F = 16,
  parameter int DW = 2 * C + 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  adv,
  input  wire                  v_i,
  input  wire  signed [DW-1:0] dot_i,
  input  wire  signed [DW-1:0] len2_i,
  input  wire  signed [C:0]    d_i [3],
  input  wire  signed [C:0]    e_i [3],
  output logic                 v_o,
  output logic [F:0]           h_o,
  output logic signed [C:0]    d_o [3],
  output logic signed [C:0]    e_o [3]
);

  import capsd_pkg::*;

  localparam int RW = DW + 1;

  logic              v_r    [F+1];
  seg_mode_t         mode_r [F+1];
  logic [RW-1:0]     rem_r  [F+1];
  logic [RW-1:0]     len2_r [F+1];
  logic [F:0]        h_r    [F+1];
  logic signed [C:0] d_r    [F+1][3];
  logic signed [C:0] e_r    [F+1][3];

  seg_mode_t mode_nxt;

  always_comb begin
    if (len2_i == '0 || dot_i[DW-1] || dot_i == '0) begin
      mode_nxt = MODE_ZERO;
    end else if (dot_i >= len2_i) begin
      mode_nxt = MODE_ONE;
    end else begin
      mode_nxt = MODE_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_r[0] <= mode_nxt;
      rem_r[0]  <= RW'(unsigned'(dot_i));
      len2_r[0] <= RW'(unsigned'(len2_i));
      h_r[0]    <= '0;
      d_r[0]    <= d_i;
      e_r[0]    <= e_i;
    end
  end

  for (genvar k = 1; k <= F; k++) begin : g_step
    logic [RW-1:0] shl;
    logic          ge;

    assign shl = {rem_r[k-1][RW-2:0], 1'b0};
    assign ge  = shl >= len2_r[k-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mode_r[k] <= mode_r[k-1];
        rem_r[k]  <= ge ? shl - len2_r[k-1] : shl;
        len2_r[k] <= len2_r[k-1];
        h_r[k]    <= {h_r[k-1][F-1:0], ge};
        d_r[k]    <= d_r[k-1];
        e_r[k]    <= e_r[k-1];
      end
    end
  end

  always_comb begin
    case (mode_r[F])
      MODE_ZERO: h_o = '0;
      MODE_ONE:  h_o = (F+1)'(1) << F;
      MODE_DIV:  h_o = h_r[F];
      default:   h_o = '0;
    endcase
  end

  assign v_o = v_r[F];
  assign d_o = d_r[F];
  assign e_o = e_r[F];

endmodule

`default_nettype wire

>>> src/capsd_back.sv
// ----------------------------------------------------------------------------
// capsd_back
// Closest-point offset Q = D - round(E * H) and its squared length.
// ----------------------------------------------------------------------------
`default_nettype none

module capsd_back #(
  parameter int C = 32,
  parameter int F = 16,
  parameter int SW = 2 * C + 6
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 adv,
  input  wire                 v_i,
  input  wire  [F:0]          h_i,
  input  wire  signed [C:0]   d_i [3],
  input  wire  signed [C:0]   e_i [3],
  output logic                v_o,
  output logic [SW-1:0]       sum_o
);

  localparam int TW = C + F + 3;
  localparam int QW = C + 2;
  localparam int SQW = 2 * QW;
  localparam logic signed [TW-1:0] HALF = TW'(1) << (F - 1);

  logic                  v1_r, v2_r, v3_r, v4_r;
  logic signed [TW-1:0]  t_r  [3];
  logic signed [C:0]     d1_r [3];
  logic signed [QW-1:0]  q_r  [3];
  logic signed [SQW-1:0] sq_r [3];
  logic [SW-1:0]         sum_r;
  logic signed [TW-1:0]  rnd  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (t_r[i] + HALF) >>> F;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t_r[i]  <= e_i[i] * $signed({1'b0, h_i});
        d1_r[i] <= d_i[i];
        q_r[i]  <= QW'(d1_r[i]) - rnd[i][QW-1:0];
        sq_r[i] <= q_r[i] * q_r[i];
      end
      sum_r <= SW'(unsigned'(sq_r[0])) + SW'(unsigned'(sq_r[1]))
             + SW'(unsigned'(sq_r[2]));
    end
  end

  assign v_o   = v4_r;
  assign sum_o = sum_r;

endmodule

`default_nettype wire

>>> src/capsd_sqrt.sv
// ----------------------------------------------------------------------------
// capsd_sqrt
// Integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module capsd_sqrt #(
  parameter int SW = 70,
  parameter int RTW = SW / 2
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              adv,
  input  wire              v_i,
  input  wire  [SW-1:0]    n_i,
  output logic             v_o,
  output logic [RTW-1:0]   root_o
);

  localparam int N = SW / 2;

  logic          v_r   [N];
  logic [SW-1:0] n_r   [N];
  logic [SW-1:0] res_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * k);
    logic          v_src;
    logic [SW-1:0] n_src, res_src, t;

    if (k == 0) begin : g_first
      assign v_src   = v_i;
      assign n_src   = n_i;
      assign res_src = '0;
    end else begin : g_next
      assign v_src   = v_r[k-1];
      assign n_src   = n_r[k-1];
      assign res_src = res_r[k-1];
    end

    assign t = res_src + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (n_src >= t) begin
          n_r[k]   <= n_src - t;
          res_r[k] <= (res_src >> 1) + BIT;
        end else begin
          n_r[k]   <= n_src;
          res_r[k] <= res_src >> 1;
        end
      end
    end
  end

  assign v_o    = v_r[N-1];
  assign root_o = res_r[N-1][RTW-1:0];

endmodule

`default_nettype wire

>>> src/capsule_signed_distance_top.sv
// ----------------------------------------------------------------------------
// capsule_signed_distance_top
// Signed distance from a sample point to a capsule, Q(C-F).F fixed point.
// ----------------------------------------------------------------------------
// Takes one point per cycle unless stalled and gives one distance per point, in
// order. The pipeline has three stages for the dot products, FRAC_BITS + 1
// for the quotient bits of the segment parameter, four for the offset and
// its squared length, COORD_BITS + 3 for the root bits and one output
// register. A held stall freezes the whole pipeline; write the endpoint and
// radius registers only while no point is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module capsule_signed_distance_top #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  signed [COORD_BITS-1:0]  in_point_x,
  input  wire  signed [COORD_BITS-1:0]  in_point_y,
  input  wire  signed [COORD_BITS-1:0]  in_point_z,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic signed [COORD_BITS-1:0]  out_distance,
  input  wire                           cfg_we,
  input  wire  [capsd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire  [COORD_BITS-1:0]         cfg_wdata
);

  import capsd_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int DW  = 2 * C + 4;
  localparam int SW  = 2 * C + 6;
  localparam int RTW = SW / 2;
  localparam int XW  = RTW + 1;
  localparam logic signed [XW-1:0] DMAX = XW'((64'(1) << (C - 1)) - 64'(1));

  logic signed [C-1:0] a_r [3];
  logic signed [C-1:0] b_r [3];
  logic [C-2:0]        radius_r;
  logic signed [C-1:0] p   [3];

  logic              adv;
  logic              fv, dv, bv, sv;
  logic signed [DW-1:0] dot, len2;
  logic signed [C:0] fd [3];
  logic signed [C:0] fe [3];
  logic signed [C:0] dd [3];
  logic signed [C:0] de [3];
  logic [F:0]        h;
  logic [SW-1:0]     sum;
  logic [RTW-1:0]    root;
  logic signed [XW-1:0] sdist;

  logic                out_valid_r;
  logic signed [C-1:0] out_distance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r[0]   <= '0;
      a_r[1]   <= '0;
      a_r[2]   <= '0;
      b_r[0]   <= '0;
      b_r[1]   <= '0;
      b_r[2]   <= '0;
      radius_r <= (C-1)'(1) << F;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_END_A_X: a_r[0]   <= cfg_wdata;
        REG_END_A_Y: a_r[1]   <= cfg_wdata;
        REG_END_A_Z: a_r[2]   <= cfg_wdata;
        REG_END_B_X: b_r[0]   <= cfg_wdata;
        REG_END_B_Y: b_r[1]   <= cfg_wdata;
        REG_END_B_Z: b_r[2]   <= cfg_wdata;
        REG_RADIUS:  radius_r <= cfg_wdata[C-2:0];
        default: ;
      endcase
    end
  end

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign p[0]     = in_point_x;
  assign p[1]     = in_point_y;
  assign p[2]     = in_point_z;

  capsd_front #(.C(C), .DW(DW)) u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .v_i(in_valid),
    .p_i(p), .a_i(a_r), .b_i(b_r),
    .v_o(fv), .dot_o(dot), .len2_o(len2), .d_o(fd), .e_o(fe)
  );

  capsd_div #(.C(C), .F(F), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv), .v_i(fv),
    .dot_i(dot), .len2_i(len2), .d_i(fd), .e_i(fe),
    .v_o(dv), .h_o(h), .d_o(dd), .e_o(de)
  );

  capsd_back #(.C(C), .F(F), .SW(SW)) u_back (
    .clk(clk), .rst_n(rst_n), .adv(adv), .v_i(dv),
    .h_i(h), .d_i(dd), .e_i(de), .v_o(bv), .sum_o(sum)
  );

  capsd_sqrt #(.SW(SW), .RTW(RTW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .adv(adv), .v_i(bv),
    .n_i(sum), .v_o(sv), .root_o(root)
  );

  assign sdist = $signed({1'b0, root}) - $signed(XW'(radius_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_distance_r <= (sdist > DMAX) ? DMAX[C-1:0] : sdist[C-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

endmodule

`default_nettype wire

>>> tb/capsule_signed_distance_chk.sv
// ----------------------------------------------------------------------------
// capsule_signed_distance_chk
// Predicts and checks the capsule distance stream.
// ----------------------------------------------------------------------------
// Keeps a copy of the capsule registers from the write port and predicts the
// signed distance of every point that enters. It queues the predictions in
// order and compares each distance word that leaves against the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module capsule_signed_distance_chk (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire signed [31:0] in_point_x,
  input  wire signed [31:0] in_point_y,
  input  wire signed [31:0] in_point_z,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire signed [31:0] out_distance,
  input  wire               cfg_we,
  input  wire        [2:0]  cfg_index,
  input  wire        [31:0] cfg_wdata,
  output int                mismatches,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import capsd_pkg::*;

  typedef logic signed [127:0] wide_t;

  logic signed [31:0] cap_a [3];
  logic signed [31:0] cap_b [3];
  logic        [30:0] cap_r;
  logic signed [31:0] dist_q [$];

  function automatic logic [127:0] root_floor(logic [127:0] n);
    logic [127:0] res;
    logic [127:0] b;
    res = '0;
    b = 128'd1 << 126;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] capsule_distance(logic signed [31:0] p [3]);
    wide_t d [3];
    wide_t e [3];
    wide_t dot;
    wide_t len2;
    wide_t h;
    wide_t t;
    wide_t q;
    wide_t sum;
    wide_t sdist;
    dot = 0;
    len2 = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = wide_t'(p[i]) - wide_t'(cap_a[i]);
      e[i] = wide_t'(cap_b[i]) - wide_t'(cap_a[i]);
      dot = dot + d[i] * e[i];
      len2 = len2 + e[i] * e[i];
    end
    if (len2 == 0 || dot <= 0) h = 0;
    else if (dot >= len2) h = 65536;
    else h = (dot <<< 16) / len2;
    for (int i = 0; i < 3; i++) begin
      t = (e[i] * h + 32768) >>> 16;
      q = d[i] - t;
      sum = sum + q * q;
    end
    sdist = wide_t'(root_floor(sum)) - wide_t'({1'b0, cap_r});
    if (sdist > 2147483647) sdist = 2147483647;
    return sdist[31:0];
  endfunction

  always @(posedge clk) begin
    logic signed [31:0] p [3];
    logic signed [31:0] want;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cap_a[i] <= '0;
        cap_b[i] <= '0;
      end
      cap_r <= 31'd65536;
      dist_q.delete();
      mismatches <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        p[0] = in_point_x;
        p[1] = in_point_y;
        p[2] = in_point_z;
        dist_q.push_back(capsule_distance(p));
      end
      if (out_valid && !out_stall) begin
        if (dist_q.size() == 0) begin
          $error("distance: no word expected, got %0d", out_distance);
          mismatches <= mismatches + 1;
        end else begin
          want = dist_q.pop_front();
          if (want !== out_distance) begin
            $error("distance: expected %0d, got %0d", want, out_distance);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_END_A_X: cap_a[0] <= cfg_wdata;
          REG_END_A_Y: cap_a[1] <= cfg_wdata;
          REG_END_A_Z: cap_a[2] <= cfg_wdata;
          REG_END_B_X: cap_b[0] <= cfg_wdata;
          REG_END_B_Y: cap_b[1] <= cfg_wdata;
          REG_END_B_Z: cap_b[2] <= cfg_wdata;
          REG_RADIUS:  cap_r <= cfg_wdata[30:0];
          default: ;
        endcase
      end
    end
  end

  assign pending = dist_q.size();

endmodule

`default_nettype wire

>>> tb/capsule_signed_distance_top_tb.sv
// ----------------------------------------------------------------------------
// capsule_signed_distance_top_tb
// Stimulus and verdict for the capsule signed distance block.
// ----------------------------------------------------------------------------
// Runs directed points around a sphere, a short segment and the widest
// segment, then random points under several capsule settings, extremes among
// them, with random input gaps and output stalls. The checker beside the block
// predicts and compares every distance word.
// ----------------------------------------------------------------------------
`default_nettype none

module capsule_signed_distance_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import capsd_pkg::*;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 70;
  localparam logic [31:0] MAXC = 32'h7fffffff;
  localparam logic [31:0] MINC = 32'h80000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [31:0] in_point_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_distance;
  logic               cfg_we = 1'b0;
  logic        [2:0]  cfg_index = '0;
  logic        [31:0] cfg_wdata = '0;
  int                 mismatches;
  int                 pending;
  int                 cycles = 0;
  int                 hold_left = 0;
  bit                 quiet = 1'b0;
  logic signed [31:0] seg_a [3];
  logic signed [31:0] seg_b [3];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  capsule_signed_distance_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_stall(out_stall), .out_distance(out_distance),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  capsule_signed_distance_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_stall(out_stall), .out_distance(out_distance),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("capsule_signed_distance_top_tb: done, errors");
      $finish;
    end
  end

  // hold the result side for a random count after each word
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall) hold_left = quiet ? 0 : $urandom_range(0, 9);
    end
  end

  task automatic send(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic set_capsule(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                             logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                             logic [31:0] rad);
    write_reg(REG_END_A_X, ax);
    write_reg(REG_END_A_Y, ay);
    write_reg(REG_END_A_Z, az);
    write_reg(REG_END_B_X, bx);
    write_reg(REG_END_B_Y, by);
    write_reg(REG_END_B_Z, bz);
    write_reg(REG_RADIUS, rad);
    cfg_we <= 1'b0;
    seg_a = '{ax, ay, az};
    seg_b = '{bx, by, bz};
  endtask

  function automatic logic [31:0] small_coord(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic signed [31:0] pick_coord(int k);
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return seg_a[k] + small_coord(1 << 18);
      2:       return seg_b[k] + small_coord(1 << 18);
      3:       return seg_a[k] + ((seg_b[k] - seg_a[k]) >>> $urandom_range(0, 4));
      4:       return $urandom_range(0, 1) ? MAXC : MINC;
      default: return small_coord(1 << 22);
    endcase
  endfunction

  task automatic random_phase(int count);
    repeat (count) send(pick_coord(0), pick_coord(1), pick_coord(2));
  endtask

  initial begin
    seg_a = '{0, 0, 0};
    seg_b = '{0, 0, 0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sphere at origin, reset registers
    send(MINC, MINC, MINC);
    send(MAXC, MAXC, MAXC);
    send(0, 0, 0);
    send(32'sd65536, 0, 0);
    send(0, -32'sd65536, 0);
    send(MAXC, MINC, 0);
    send(32'hffff_ffff, 1, 32'h5555_5555);
    settle();

    // short segment along x, ten units long
    set_capsule(0, 0, 0, 32'd655360, 0, 0, 32'd32768);
    send(0, 0, 0);
    send(32'd655360, 0, 0);
    send(-32'sd131072, 0, 0);
    send(32'd786432, 32'd65536, 0);
    send(32'd327680, 32'd65536, 0);
    send(32'd327681, 0, 32'd98304);
    send(32'd1, 32'd1, 32'd1);
    send(MINC, MAXC, MINC);
    settle();

    // widest segment, largest radius
    set_capsule(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC);
    send(0, 0, 0);
    send(MINC, MAXC, 0);
    send(MAXC, MAXC, MAXC);
    send(MINC, MINC, MAXC);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      quiet = (ph == 2 || ph == 5);
      case (ph % 4)
        0: set_capsule(small_coord(1 << 20), small_coord(1 << 20), small_coord(1 << 20),
                       small_coord(1 << 20), small_coord(1 << 20), small_coord(1 << 20),
                       $urandom_range(0, 1 << 20));
        1: begin
          logic [31:0] cx, cy, cz;
          cx = $urandom;
          cy = $urandom;
          cz = $urandom;
          set_capsule(cx, cy, cz, cx, cy, cz, 0);
        end
        2: set_capsule($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom);
        default: set_capsule(MAXC, 0, MINC, MINC, 0, MAXC, $urandom_range(0, 1) ? MAXC : 0);
      endcase
      random_phase(100);
      settle();
    end
    quiet = 1'b0;

    if (mismatches == 0) $display("capsule_signed_distance_top_tb: done, clean");
    else $display("capsule_signed_distance_top_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
src/capsd_pkg.sv
src/capsd_front.sv
src/capsd_div.sv
src/capsd_back.sv
src/capsd_sqrt.sv
src/capsule_signed_distance_top.sv
tb/capsule_signed_distance_chk.sv
tb/capsule_signed_distance_top_tb.sv
